/* design/lcd4_pkg.sv */
package lcd4_pkg;

    localparam int DefMaxScrollSteps = 16;
    localparam int ScrollLimit       = 16;
    localparam int ScrollCntW        = 5;
    localparam int PcW               = 4;

    typedef enum logic [2:0] {
        OP_INIT   = 3'd0,
        OP_CLEAR  = 3'd1,
        OP_CURSOR = 3'd2,
        OP_SCROLL = 3'd3,
        OP_CHAR   = 3'd4,
        OP_NUMBER = 3'd5
    } op_t;

    typedef enum logic [2:0] {
        SRC_CONST,
        SRC_CURSOR,
        SRC_SCROLL,
        SRC_CHAR,
        SRC_HUND,
        SRC_TENS,
        SRC_UNITS
    } src_t;

    typedef enum logic [1:0] {
        COND_NONE,
        COND_SKIP_HUND,
        COND_SKIP_TENS,
        COND_LOOP
    } cond_t;

    typedef struct packed {
        src_t       src;
        cond_t      cond;
        logic       rs;
        logic       fin;
        logic [7:0] data;
    } ctrl_word_t;

    localparam logic [PcW-1:0] PC_INIT   = 4'd0;
    localparam logic [PcW-1:0] PC_CLEAR  = 4'd6;
    localparam logic [PcW-1:0] PC_CURSOR = 4'd7;
    localparam logic [PcW-1:0] PC_SCROLL = 4'd8;
    localparam logic [PcW-1:0] PC_CHAR   = 4'd9;
    localparam logic [PcW-1:0] PC_NUMBER = 4'd10;

    function automatic ctrl_word_t ucode_rom(input logic [PcW-1:0] addr);
        ctrl_word_t w;
        w = '{src: SRC_CONST, cond: COND_NONE, rs: 1'b0, fin: 1'b1, data: 8'h00};
        unique case (addr)
            4'd0:  w = '{SRC_CONST,  COND_NONE,      1'b0, 1'b0, 8'h33};
            4'd1:  w = '{SRC_CONST,  COND_NONE,      1'b0, 1'b0, 8'h32};
            4'd2:  w = '{SRC_CONST,  COND_NONE,      1'b0, 1'b0, 8'h28};
            4'd3:  w = '{SRC_CONST,  COND_NONE,      1'b0, 1'b0, 8'h0C};
            4'd4:  w = '{SRC_CONST,  COND_NONE,      1'b0, 1'b0, 8'h01};
            4'd5:  w = '{SRC_CONST,  COND_NONE,      1'b0, 1'b1, 8'h06};
            4'd6:  w = '{SRC_CONST,  COND_NONE,      1'b0, 1'b1, 8'h01};
            4'd7:  w = '{SRC_CURSOR, COND_NONE,      1'b0, 1'b1, 8'h00};
            4'd8:  w = '{SRC_SCROLL, COND_LOOP,      1'b0, 1'b1, 8'h00};
            4'd9:  w = '{SRC_CHAR,   COND_NONE,      1'b1, 1'b1, 8'h00};
            4'd10: w = '{SRC_HUND,   COND_SKIP_HUND, 1'b1, 1'b0, 8'h00};
            4'd11: w = '{SRC_TENS,   COND_SKIP_TENS, 1'b1, 1'b0, 8'h00};
            4'd12: w = '{SRC_UNITS,  COND_NONE,      1'b1, 1'b1, 8'h00};
            default: w = '{SRC_CONST, COND_NONE, 1'b0, 1'b1, 8'h00};
        endcase
        return w;
    endfunction

    function automatic logic [PcW-1:0] entry_addr(input logic [2:0] opcode);
        logic [PcW-1:0] a;
        a = PC_INIT;
        unique case (opcode)
            OP_INIT:   a = PC_INIT;
            OP_CLEAR:  a = PC_CLEAR;
            OP_CURSOR: a = PC_CURSOR;
            OP_SCROLL: a = PC_SCROLL;
            OP_CHAR:   a = PC_CHAR;
            OP_NUMBER: a = PC_NUMBER;
            default:   a = PC_INIT;
        endcase
        return a;
    endfunction

endpackage

/* design/lcd_4bit_command_sequencer.sv */
// after an operation is accepted, its first nibble word is registered once the output slot is free;
//   for a printed number below 100, each suppressed leading zero first takes its own skip step
// throughput: one nibble word per cycle while m_tready allows and no skip step runs,
//   2 to 32 words per operation, high then low nibble per byte; a no-output op leaves it idle
// the microcode step counter and the single output register set the pace
// reset (aresetn low, synchronous) idles the sequencer and drops m_tvalid
module lcd_4bit_command_sequencer #(
    parameter int MAX_SCROLL_STEPS = lcd4_pkg::DefMaxScrollSteps
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // column[5:0], row, direction, scroll_steps, char_code, number
    input  logic [2:0]  s_tuser,   // opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // nibble[3:0], zero pad
    output logic        m_tuser,   // register_select
    output logic        m_tlast
);
    import lcd4_pkg::*;

    localparam int ScrollCap = (MAX_SCROLL_STEPS < ScrollLimit) ? MAX_SCROLL_STEPS : ScrollLimit;

    logic                  busy_reg, busy_next;
    logic [PcW-1:0]        pc_reg, pc_next;
    logic                  half_reg, half_next;
    logic [ScrollCntW-1:0] steps_reg, steps_next;
    logic [7:0]            cursor_reg, cursor_next;
    logic                  dir_reg, dir_next;
    logic [7:0]            char_reg, char_next;
    logic [1:0]            hund_reg, hund_next;
    logic [6:0]            rem_reg, rem_next;
    logic                  out_valid_reg, out_valid_next;
    logic [3:0]            out_nibble_reg, out_nibble_next;
    logic                  out_rs_reg, out_rs_next;
    logic                  out_last_reg, out_last_next;

    ctrl_word_t            ctrl;
    logic [3:0]            tens;
    logic [3:0]            units;
    logic [14:0]           tens_prod;
    logic [7:0]            cur_byte;
    logic                  skip;
    logic                  slot;
    logic                  emit;
    logic                  accept;
    logic [7:0]            in_steps;
    logic [7:0]            in_num;
    logic [1:0]            in_hund;
    logic [ScrollCntW-1:0] in_steps_sat;

    assign ctrl      = ucode_rom(pc_reg);
    assign tens_prod = rem_reg * 8'd205;
    assign tens      = tens_prod[14:11];
    assign units     = 4'(rem_reg - 7'({tens, 3'b000} + {2'b00, tens, 1'b0}));

    assign in_steps  = s_tdata[15:8];
    assign in_num    = s_tdata[31:24];
    assign in_hund   = (in_num >= 8'd200) ? 2'd2 : ((in_num >= 8'd100) ? 2'd1 : 2'd0);
    assign in_steps_sat = (in_steps > 8'(ScrollCap)) ? ScrollCntW'(ScrollCap)
                                                     : ScrollCntW'(in_steps);

    assign accept = s_tvalid && !busy_reg;
    assign slot   = !out_valid_reg || m_tready;
    assign skip   = busy_reg &&
                    ((ctrl.cond == COND_SKIP_HUND && hund_reg == 2'd0) ||
                     (ctrl.cond == COND_SKIP_TENS && hund_reg == 2'd0 && tens == 4'd0));
    assign emit   = busy_reg && !skip && slot;

    always_comb begin
        unique case (ctrl.src)
            SRC_CONST:  cur_byte = ctrl.data;
            SRC_CURSOR: cur_byte = cursor_reg;
            SRC_SCROLL: cur_byte = dir_reg ? 8'h1C : 8'h18;
            SRC_CHAR:   cur_byte = char_reg;
            SRC_HUND:   cur_byte = 8'h30 + {6'd0, hund_reg};
            SRC_TENS:   cur_byte = 8'h30 + {4'd0, tens};
            SRC_UNITS:  cur_byte = 8'h30 + {4'd0, units};
            default:    cur_byte = ctrl.data;
        endcase
    end

    always_comb begin
        busy_next       = busy_reg;
        pc_next         = pc_reg;
        half_next       = half_reg;
        steps_next      = steps_reg;
        cursor_next     = cursor_reg;
        dir_next        = dir_reg;
        char_next       = char_reg;
        hund_next       = hund_reg;
        rem_next        = rem_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_nibble_next = out_nibble_reg;
        out_rs_next     = out_rs_reg;
        out_last_next   = out_last_reg;

        if (accept) begin
            pc_next     = entry_addr(s_tuser);
            half_next   = 1'b0;
            steps_next  = in_steps_sat;
            cursor_next = (s_tdata[6] ? 8'hC0 : 8'h80) + {2'b00, s_tdata[5:0]};
            dir_next    = s_tdata[7];
            char_next   = s_tdata[23:16];
            hund_next   = in_hund;
            rem_next    = 7'(in_num - ((in_hund == 2'd2) ? 8'd200 :
                                       ((in_hund == 2'd1) ? 8'd100 : 8'd0)));
            busy_next   = (s_tuser <= OP_NUMBER) &&
                          !(s_tuser == OP_SCROLL && in_steps == 8'd0);
        end else if (skip) begin
            pc_next = pc_reg + 1'b1;
        end else if (emit) begin
            out_valid_next = 1'b1;
            out_rs_next    = ctrl.rs;
            if (!half_reg) begin
                out_nibble_next = cur_byte[7:4];
                out_last_next   = 1'b0;
                half_next       = 1'b1;
            end else begin
                out_nibble_next = cur_byte[3:0];
                half_next       = 1'b0;
                out_last_next   = 1'b0;
                if (ctrl.cond == COND_LOOP && steps_reg > ScrollCntW'(1)) begin
                    steps_next = steps_reg - 1'b1;
                end else if (ctrl.fin) begin
                    busy_next     = 1'b0;
                    out_last_next = 1'b1;
                end else begin
                    pc_next = pc_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            pc_reg        <= PC_INIT;
            half_reg      <= 1'b0;
        end else begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
            pc_reg        <= pc_next;
            half_reg      <= half_next;
        end
        steps_reg      <= steps_next;
        cursor_reg     <= cursor_next;
        dir_reg        <= dir_next;
        char_reg       <= char_next;
        hund_reg       <= hund_next;
        rem_reg        <= rem_next;
        out_nibble_reg <= out_nibble_next;
        out_rs_reg     <= out_rs_next;
        out_last_reg   <= out_last_next;
    end

    assign s_tready = !busy_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, out_nibble_reg};
    assign m_tuser  = out_rs_reg;
    assign m_tlast  = out_last_reg;

endmodule
